>>> rtl/core/mfic_pkg.sv
// Package for the modal frequency integer check block.
// Holds payload structs, controller/datapath command and status types, and
// hash and register constants. No dependencies.
package mfic_pkg;

  localparam int TableDepthDflt = 1024;
  localparam int ValW           = 32;
  localparam int CutW           = 11;
  localparam int EpochW         = 8;
  localparam int ApbAw          = 3;
  localparam int ApbDw          = 32;

  localparam logic RegIdxCutoff = 1'b0;

  localparam logic [31:0] MixMul1 = 32'h7feb352d;
  localparam logic [31:0] MixMul2 = 32'h846ca68b;
  localparam int          MixShA  = 16;
  localparam int          MixShB  = 15;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   column_end;
  } in_t;

  typedef struct packed {
    logic keep;
    logic overflow;
  } out_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_EVAL,
    S_H2,
    S_H3,
    S_H4,
    S_HOME,
    S_RD,
    S_CMP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic hash;
    logic home;
    logic probe;
    logic epoch_adv;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic found;
    logic hit;
    logic epoch_wrap;
    logic sweep_last;
  } status_t;

endpackage

>>> rtl/core/mfic_dp.sv
// Datapath: input capture, hash pipeline, modulo reduction, probe pointer
// and the slot table memory with epoch tags. Depends on mfic_pkg.
module mfic_dp #(
  parameter int TABLE_DEPTH = mfic_pkg::TableDepthDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mfic_pkg::in_t               in_data_i,
  input  logic [mfic_pkg::CutW-1:0]   cutoff_i,
  input  mfic_pkg::cmd_t              cmd_i,
  output mfic_pkg::status_t           status_o
);

  localparam int IdxW      = $clog2(TABLE_DEPTH);
  localparam int HalfDepth = TABLE_DEPTH / 2;
  localparam int CntW      = $clog2(HalfDepth + 1);
  localparam int CmpW      = (CntW > mfic_pkg::CutW) ? CntW : mfic_pkg::CutW;
  localparam int KeyW      = mfic_pkg::ValW;
  localparam int EpW       = mfic_pkg::EpochW;
  localparam int EntW      = EpW + KeyW + CntW;
  localparam int RemW      = IdxW + 1;

  localparam logic [63:0]     Recip64 = 64'h1_0000_0000 / 64'(TABLE_DEPTH);
  localparam logic [31:0]     Recip   = Recip64[31:0];
  localparam logic [31:0]     DepthW  = 32'(TABLE_DEPTH);
  localparam logic [RemW-1:0] DepthR  = RemW'(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  logic [KeyW-1:0] value_q;
  logic            last_q;
  logic [31:0]     h1_q, h2_q, h3_q;
  logic [63:0]     prod_q;
  logic [RemW-1:0] rem_q;
  logic [IdxW-1:0] pos_q;
  logic [EntW-1:0] rd_q;
  logic [EpW-1:0]  epoch_q;
  logic [IdxW-1:0] sweep_q;

  logic [EntW-1:0] mem [TABLE_DEPTH];

  logic [31:0]     mix1, mix2, h1_d, h2_d, h3_d, diff;
  logic [63:0]     prod_d, qd;
  logic [RemW-1:0] rem_d, rem_sub;
  logic [IdxW-1:0] home_d, pos_next;
  logic [EpW-1:0]  rd_epoch;
  logic [KeyW-1:0] rd_key;
  logic [CntW-1:0] rd_cnt, new_cnt;
  logic            used, match, found, hit;
  logic            we;
  logic [IdxW-1:0] wa;
  logic [EntW-1:0] wd;
  logic            sweep_last;

  assign mix1   = value_q ^ (value_q >> mfic_pkg::MixShA);
  assign h1_d   = mix1 * mfic_pkg::MixMul1;
  assign mix2   = h1_q ^ (h1_q >> mfic_pkg::MixShB);
  assign h2_d   = mix2 * mfic_pkg::MixMul2;
  assign h3_d   = h2_q ^ (h2_q >> mfic_pkg::MixShA);
  assign prod_d = 64'(h3_d) * 64'(Recip);

  assign qd      = 64'(prod_q[63:32]) * 64'(DepthW);
  assign diff    = h3_q - qd[31:0];
  assign rem_d   = diff[RemW-1:0];
  assign rem_sub = rem_q - DepthR;
  assign home_d  = (rem_q >= DepthR) ? rem_sub[IdxW-1:0] : rem_q[IdxW-1:0];

  assign pos_next = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;

  assign rd_epoch = rd_q[EntW-1 -: EpW];
  assign rd_key   = rd_q[CntW +: KeyW];
  assign rd_cnt   = rd_q[CntW-1:0];
  assign used     = (rd_epoch == epoch_q);
  assign match    = used && (rd_key == value_q);
  assign found    = !used || match;
  assign new_cnt  = used ? rd_cnt + 1'b1 : CntW'(1);
  assign hit      = CmpW'(new_cnt) >= CmpW'(cutoff_i);

  assign sweep_last = (sweep_q == LastIdx);

  assign we = cmd_i.sweep || (cmd_i.probe && found);
  assign wa = cmd_i.sweep ? sweep_q : pos_q;
  assign wd = cmd_i.sweep ? '0 : {epoch_q, value_q, new_cnt};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_data_i.value;
      last_q  <= in_data_i.column_end;
    end
    if (cmd_i.hash) begin
      h1_q   <= h1_d;
      h2_q   <= h2_d;
      h3_q   <= h3_d;
      prod_q <= prod_d;
      rem_q  <= rem_d;
    end
    if (cmd_i.home) begin
      pos_q <= home_d;
    end else if (cmd_i.probe && !found) begin
      pos_q <= pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      sweep_q <= '0;
    end else begin
      if (cmd_i.sweep) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
      if (cmd_i.sweep && sweep_last) begin
        epoch_q <= EpW'(1);
      end else if (cmd_i.epoch_adv) begin
        epoch_q <= epoch_q + 1'b1;
      end
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.last       = last_q;
    status_o.found      = found;
    status_o.hit        = hit;
    status_o.epoch_wrap = (epoch_q == '1);
    status_o.sweep_last = sweep_last;
  end

endmodule

>>> rtl/core/mfic_ctrl.sv
// Controller: sequencing state machine, column state and result register.
// Drives mfic_dp through cmd_t and reads status_t. Depends on mfic_pkg.
module mfic_ctrl #(
  parameter int TABLE_DEPTH = mfic_pkg::TableDepthDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mfic_pkg::out_t              out_data_o,
  input  logic [mfic_pkg::CutW-1:0]   cutoff_i,
  input  mfic_pkg::status_t           status_i,
  output mfic_pkg::cmd_t              cmd_o
);

  localparam int HalfDepth = TABLE_DEPTH / 2;
  localparam int ItemsW    = $clog2(HalfDepth + 2);
  localparam logic [ItemsW-1:0] HalfC  = ItemsW'(HalfDepth);
  localparam logic [ItemsW-1:0] HalfP1 = ItemsW'(HalfDepth + 1);

  mfic_pkg::state_e state_q, state_d;
  logic              decided_q, decided_d;
  logic [ItemsW-1:0] items_q, items_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  mfic_pkg::out_t    out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfic_pkg::S_SWEEP;
      decided_q   <= 1'b0;
      items_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      decided_q   <= decided_d;
      items_q     <= items_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    decided_d   = decided_q;
    items_d     = items_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      mfic_pkg::S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = mfic_pkg::S_IDLE;
        end
      end
      mfic_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mfic_pkg::S_EVAL;
        end
      end
      mfic_pkg::S_EVAL: begin
        cmd_o.hash = 1'b1;
        if (decided_q) begin
          if (status_i.last) begin
            decided_d       = 1'b0;
            items_d         = '0;
            cmd_o.epoch_adv = 1'b1;
            state_d = status_i.epoch_wrap ? mfic_pkg::S_SWEEP : mfic_pkg::S_IDLE;
          end else begin
            state_d = mfic_pkg::S_IDLE;
          end
        end else if (cutoff_i == '0) begin
          hit_d   = 1'b1;
          state_d = mfic_pkg::S_EMIT;
        end else if (items_q >= HalfC) begin
          items_d = HalfP1;
          hit_d   = 1'b0;
          state_d = status_i.last ? mfic_pkg::S_EMIT : mfic_pkg::S_IDLE;
        end else begin
          items_d = items_q + 1'b1;
          state_d = mfic_pkg::S_H2;
        end
      end
      mfic_pkg::S_H2: begin
        cmd_o.hash = 1'b1;
        state_d    = mfic_pkg::S_H3;
      end
      mfic_pkg::S_H3: begin
        cmd_o.hash = 1'b1;
        state_d    = mfic_pkg::S_H4;
      end
      mfic_pkg::S_H4: begin
        cmd_o.hash = 1'b1;
        state_d    = mfic_pkg::S_HOME;
      end
      mfic_pkg::S_HOME: begin
        cmd_o.home = 1'b1;
        state_d    = mfic_pkg::S_RD;
      end
      mfic_pkg::S_RD: begin
        state_d = mfic_pkg::S_CMP;
      end
      mfic_pkg::S_CMP: begin
        cmd_o.probe = 1'b1;
        if (status_i.found) begin
          hit_d = status_i.hit;
          if (status_i.hit || status_i.last) begin
            state_d = mfic_pkg::S_EMIT;
          end else begin
            state_d = mfic_pkg::S_IDLE;
          end
        end else begin
          state_d = mfic_pkg::S_RD;
        end
      end
      mfic_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_d.keep     = !hit_q;
          out_d.overflow = (items_q > HalfC);
          if (status_i.last) begin
            decided_d       = 1'b0;
            items_d         = '0;
            cmd_o.epoch_adv = 1'b1;
            state_d = status_i.epoch_wrap ? mfic_pkg::S_SWEEP : mfic_pkg::S_IDLE;
          end else begin
            decided_d = 1'b1;
            state_d   = mfic_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = mfic_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_items_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= HalfP1)
    else $error("items count beyond half table");

  a_emit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfic_pkg::S_EMIT && out_valid_q && !out_ready_i)
    |=> state_q == mfic_pkg::S_EMIT)
    else $error("result dropped while output busy");

  a_no_probe_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfic_pkg::S_HOME) |-> !decided_q)
    else $error("probe started on a decided column");

  a_probe_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfic_pkg::S_CMP && status_i.found)
    |=> (state_q == mfic_pkg::S_EMIT || state_q == mfic_pkg::S_IDLE))
    else $error("probe did not terminate on found slot");

endmodule

>>> rtl/core/modal_frequency_int_check.sv
// Top level of the modal frequency integer check: APB cutoff register,
// controller and datapath. Depends on mfic_pkg, mfic_ctrl, mfic_dp.
//
//   channel   signals                                   direction
//   input     in_valid_i / in_ready_o / in_data_i       in
//   result    out_valid_o / out_ready_i / out_data_o    out
//   config    psel penable pwrite paddr pwdata prdata   APB
//
// One item per transaction; one item in flight at a time.
// Decided, zero-cutoff or overlong-column items do not touch the table. Counted items
// are hashed, then take linear probe steps (table memory read and compare), and a
// result is emitted when one is produced. After reset a clearing pass over every
// table slot runs before the first item, and again after every 255th column.
// A stalled result is held in the output register while the next item runs.
module modal_frequency_int_check #(
  parameter int TABLE_DEPTH = mfic_pkg::TableDepthDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mfic_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mfic_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mfic_pkg::ApbAw-1:0]   paddr,
  input  logic [mfic_pkg::ApbDw-1:0]   pwdata,
  output logic [mfic_pkg::ApbDw-1:0]   prdata,
  output logic                         pready
);

  logic [mfic_pkg::CutW-1:0] cutoff_q;
  logic                      sel_cutoff;
  mfic_pkg::cmd_t            cmd;
  mfic_pkg::status_t         status;

  assign pready     = 1'b1;
  assign sel_cutoff = (paddr[mfic_pkg::ApbAw-1] == mfic_pkg::RegIdxCutoff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
    end else if (psel && penable && pwrite && pready && sel_cutoff) begin
      cutoff_q <= pwdata[mfic_pkg::CutW-1:0];
    end
  end

  assign prdata = sel_cutoff ? mfic_pkg::ApbDw'(cutoff_q) : '0;

  mfic_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cutoff_i    (cutoff_q),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mfic_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cutoff_i  (cutoff_q),
    .cmd_i     (cmd),
    .status_o  (status)
  );

endmodule

>>> bench/modal_frequency_int_check_test.sv
// Self-checking bench for modal_frequency_int_check: directed table, then random columns;
// typed rows use scripted results, the rest an in-bench hash-table frequency counter.
// Depends on mfic_pkg and the modal_frequency_int_check RTL only.
`timescale 1ns / 100ps

module modal_frequency_int_check_test;

  localparam int TableDepth = mfic_pkg::TableDepthDflt;
  localparam int Half       = TableDepth / 2;
  localparam int CutMax     = 1024;
  localparam int ItemTarget = 1800;
  localparam int DrainCycles = 2400;
  localparam int StallLimit = 20000;
  localparam logic [11:0] KeepCut = 12'hFFF;
  localparam logic [mfic_pkg::ApbAw-1:0] CutoffAddr =
    mfic_pkg::ApbAw'(4 * int'(mfic_pkg::RegIdxCutoff));
  localparam int NumRows = 20;

  typedef struct packed {
    logic [11:0] cut;
    logic [31:0] value;
    logic [9:0]  reps;
    logic        last;
    logic        typed;
    logic        exp_any;
    logic        exp_keep;
    logic        exp_ovf;
  } drow_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  mfic_pkg::in_t     in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  mfic_pkg::out_t    out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [mfic_pkg::ApbAw-1:0] paddr;
  logic [mfic_pkg::ApbDw-1:0] pwdata;
  logic [mfic_pkg::ApbDw-1:0] prdata;
  logic              pready;

  logic [31:0]       tally_key [TableDepth];
  logic [9:0]        tally_cnt [TableDepth];
  bit                tally_used [TableDepth];
  bit                column_decided;
  logic [9:0]        column_len;
  logic [mfic_pkg::CutW-1:0] cutoff_shadow;
  int unsigned       counted_items;

  mfic_pkg::out_t    verdict_q [$];
  mfic_pkg::out_t    oldest_verdict;
  int unsigned       mismatches = 0;
  int unsigned       ready_hold;
  bit                take_burst = 1'b0;
  bit                send_burst;
  int unsigned       idle_cycles = 0;

  logic [31:0]       edge_pool [10];
  drow_t             script [NumRows];

  modal_frequency_int_check #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] scramble32(input logic [31:0] v);
    logic [31:0] h;
    h = v;
    h = h ^ (h >> mfic_pkg::MixShA);
    h = h * mfic_pkg::MixMul1;
    h = h ^ (h >> mfic_pkg::MixShB);
    h = h * mfic_pkg::MixMul2;
    h = h ^ (h >> mfic_pkg::MixShA);
    return h;
  endfunction

  function automatic logic [31:0] value_at_slot(input int unsigned slot);
    logic [31:0] v;
    do v = $urandom; while (scramble32(v) % TableDepth != slot);
    return v;
  endfunction

  function automatic void clear_column();
    foreach (tally_used[i]) tally_used[i] = 1'b0;
    column_decided = 1'b0;
    column_len = '0;
  endfunction

  // Count one element; return 1 when it closes with a verdict.
  function automatic bit tally_item(input mfic_pkg::in_t x, output mfic_pkg::out_t verdict);
    logic [31:0] v;
    int unsigned pos;
    bit hit;
    v = x.value;
    hit = 1'b0;
    verdict = '0;
    if (column_decided) begin
      if (x.column_end) clear_column();
      return 1'b0;
    end
    if (cutoff_shadow == '0) begin
      hit = 1'b1;
    end else if (column_len >= Half) begin
      column_len = 10'(Half + 1);
    end else begin
      column_len = column_len + 10'd1;
      pos = scramble32(v) % TableDepth;
      while (tally_used[pos] && tally_key[pos] != v) pos = (pos + 1) % TableDepth;
      if (!tally_used[pos]) begin
        tally_used[pos] = 1'b1;
        tally_key[pos] = v;
        tally_cnt[pos] = 10'd1;
      end else begin
        tally_cnt[pos] = tally_cnt[pos] + 10'd1;
      end
      if ({1'b0, tally_cnt[pos]} >= cutoff_shadow) hit = 1'b1;
    end
    verdict.overflow = (column_len > Half);
    if (hit) begin
      verdict.keep = 1'b0;
      if (x.column_end) clear_column();
      else column_decided = 1'b1;
      return 1'b1;
    end
    if (x.column_end) begin
      verdict.keep = 1'b1;
      clear_column();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic offer_item(input mfic_pkg::in_t x);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    counted_items++;
  endtask

  task automatic feed(input mfic_pkg::in_t x);
    mfic_pkg::out_t verdict;
    offer_item(x);
    if (tally_item(x, verdict)) verdict_q.push_back(verdict);
  endtask

  // Hold off until every verdict is in and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_cutoff(input logic [mfic_pkg::CutW-1:0] c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CutoffAddr;
    pwdata  <= mfic_pkg::ApbDw'(c);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[mfic_pkg::CutW-1:0] !== c) begin
      $display("%0t: cutoff readback expected %0d actual %0d", $time, c,
               prdata[mfic_pkg::CutW-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cutoff_shadow = c;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold = 0;
    end else if (out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result expected none actual keep=%b overflow=%b", $time,
                 out_data_o.keep, out_data_o.overflow);
        mismatches++;
      end else begin
        oldest_verdict = verdict_q.pop_front();
        if (out_data_o.keep !== oldest_verdict.keep) begin
          $display("%0t: keep expected %b actual %b", $time,
                   oldest_verdict.keep, out_data_o.keep);
          mismatches++;
        end
        if (out_data_o.overflow !== oldest_verdict.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   oldest_verdict.overflow, out_data_o.overflow);
          mismatches++;
        end
      end
      ready_hold = take_burst ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
      out_ready_i <= (ready_hold == 0);
    end else if (!out_ready_i) begin
      if (ready_hold > 0) ready_hold--;
      if (ready_hold == 0) out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("modal_frequency_int_check_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    drow_t       row;
    mfic_pkg::in_t  item;
    mfic_pkg::out_t typed_verdict;
    mfic_pkg::out_t guess;
    logic [31:0] col_pool [6];
    logic [mfic_pkg::CutW-1:0] next_cut;
    int unsigned len;
    int unsigned columns;
    bit          long_col;
    int          k;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    counted_items = 0;
    cutoff_shadow = '0;
    send_burst    = 1'b0;
    clear_column();

    for (k = 0; k < 5; k++) edge_pool[k] = value_at_slot(TableDepth - 1);
    edge_pool[5] = value_at_slot(TableDepth - 2);
    edge_pool[6] = value_at_slot(TableDepth - 2);
    edge_pool[7] = value_at_slot(0);
    edge_pool[8] = value_at_slot(0);
    edge_pool[9] = value_at_slot(1);

    script = '{
      '{KeepCut, 32'h0000_0000, 10'd1,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{KeepCut, 32'h7fff_ffff, 10'd1,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{KeepCut, 32'h8000_0000, 10'd1,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{KeepCut, 32'hffff_ffff, 10'd1,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
      '{12'd1,   32'h0000_0005, 10'd1,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
      '{12'd2,   32'h0000_0005, 10'd1,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{12'd2,   32'h0000_0005, 10'd1,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{12'd2,   32'h0000_0007, 10'd1,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
      '{12'd2,   32'h0000_0001, 10'd3,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{12'd1024, 32'h8000_0000, 10'd1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{12'd1024, 32'h7fff_ffff, 10'd1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{12'd1024, 32'hffff_ffff, 10'd1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{12'd1024, 32'h0000_0000, 10'd1,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{12'd1024, 32'hffff_ffff, 10'd1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{12'd1024, 32'h0000_03e8, 10'd513, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
      '{12'd1024, 32'h0002_0000, 10'd512, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{12'd3,   32'h0000_0009, 10'd1,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{12'd3,   32'h0000_0009, 10'd1,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{12'd3,   32'h0000_0009, 10'd1,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{12'd5,   32'haaaa_aaaa, 10'd1,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      row = script[r];
      if (row.cut != KeepCut && row.cut[mfic_pkg::CutW-1:0] != cutoff_shadow) begin
        settle();
        program_cutoff(row.cut[mfic_pkg::CutW-1:0]);
      end
      for (k = 0; k < int'(row.reps); k++) begin
        item.value      = row.value + k;
        item.column_end = row.last && (k == int'(row.reps) - 1);
        if (row.typed) begin
          offer_item(item);
          void'(tally_item(item, guess));
          if (k == int'(row.reps) - 1 && row.exp_any) begin
            typed_verdict.keep     = row.exp_keep;
            typed_verdict.overflow = row.exp_ovf;
            verdict_q.push_back(typed_verdict);
          end
        end else begin
          feed(item);
        end
      end
    end

    while (counted_items < ItemTarget) begin
      case ($urandom_range(0, 9))
        0:       next_cut = '0;
        1:       next_cut = mfic_pkg::CutW'(CutMax);
        2:       next_cut = mfic_pkg::CutW'($urandom_range(1, CutMax));
        default: next_cut = mfic_pkg::CutW'($urandom_range(1, 5));
      endcase
      settle();
      program_cutoff(next_cut);
      columns = $urandom_range(4, 16);
      repeat (columns) begin
        long_col = (cutoff_shadow >= 8) && ($urandom_range(0, 99) == 0);
        if (long_col) len = $urandom_range(505, 530);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(11, 60);
        else len = $urandom_range(1, 10);
        for (int p = 0; p < 6; p++) begin
          case ($urandom_range(0, 3))
            0:       col_pool[p] = edge_pool[$urandom_range(0, 9)];
            1:       col_pool[p] = $urandom_range(0, 15);
            default: col_pool[p] = $urandom;
          endcase
        end
        for (k = 0; k < int'(len); k++) begin
          if (long_col || $urandom_range(0, 9) >= 7) item.value = $urandom;
          else item.value = col_pool[$urandom_range(0, 5)];
          item.column_end = (k == int'(len) - 1);
          feed(item);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("modal_frequency_int_check_test: PASS");
    end else begin
      $display("modal_frequency_int_check_test: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mfic_pkg.sv
rtl/core/mfic_dp.sv
rtl/core/mfic_ctrl.sv
rtl/core/modal_frequency_int_check.sv
bench/modal_frequency_int_check_test.sv
